// ===== design/rrts_pkg.sv =====
// -----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round-robin time-slice scheduler.
// -----------------------------------------------------------------------------
package rrts_pkg;

   localparam int MAX_JOBS_DEFAULT = 64;

   localparam int OPCODE_W  = 2;
   localparam int BURST_W   = 16;
   localparam int QUANTUM_W = 16;
   localparam int LEN_W     = 16;
   localparam int STATUS_W  = 3;
   localparam int JOB_IDX_W = 6;
   localparam int CLK_W     = 23;
   localparam int WAIT_W    = 32;
   localparam int JOB_CNT_W = 7;

   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd4;

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND   = 2'd0,
      OP_DISPATCH = 2'd1,
      OP_CLEAR    = 2'd2,
      OP_UNUSED   = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_APPENDED   = 3'd0,
      STATUS_DISPATCHED = 3'd1,
      STATUS_ALL_DONE   = 3'd2,
      STATUS_FULL       = 3'd3,
      STATUS_CLEARED    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_DONE = 2'd2
   } state_type;

   typedef struct packed {
      opcode_type           opcode;
      logic [BURST_W-1:0]   burst;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [JOB_IDX_W-1:0] job_index;
      logic [CLK_W-1:0]     slice_start;
      logic [LEN_W-1:0]     slice_length;
      logic                 job_finished;
      logic [CLK_W-1:0]     clock_after;
      logic [WAIT_W-1:0]    wait_sum;
      logic [JOB_CNT_W-1:0] job_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic found_valid;
      logic out_free;
   } stat_type;

endpackage

// ===== design/round_robin_time_slice_scheduler.sv =====
// -----------------------------------------------------------------------------
// round_robin_time_slice_scheduler
// Fixed-quantum round-robin scheduler over a table of job burst times.
// -----------------------------------------------------------------------------
// usage
//   req channel (req_valid / req_stall / req_data): one command per transfer,
//     append a burst, dispatch the next slice, or clear the table; the unused
//     opcode is taken and dropped without a result
//   rsp channel (rsp_valid / rsp_stall / rsp_data): exactly one result per
//     append, dispatch or clear command, in command order
//   csr port: csr_wr_en / csr_wr_data write the quantum; the user must write
//     it only while idle, the block itself does not enforce this
//   append, clear, full drop and all-finished: accepted in idle, result
//     registered on commit; no new request is taken before that commit
//   dispatch: accept, execute and commit states in order, result registered
//     on commit and no new request taken before it; a read-modify-write of
//     the remaining-time ram (read on accept, update in the execute cycle,
//     wait sum on commit)
//   the pending job is found in the accept cycle by a rotating priority
//     encoder over the pending mask
// reset: empty table, pointer, clock and wait sum zero, quantum 4; the
//   burst and remaining-time rams are not cleared, their read data is used
//   only for an entry that has been written
// stall: a result waiting in the output register does not block the next
//   request, which runs up to its commit and holds there until the
//   output register is taken
// -----------------------------------------------------------------------------
module round_robin_time_slice_scheduler import rrts_pkg::*; #(
   parameter int MAX_JOBS = MAX_JOBS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   // quantum register
   input  logic                 csr_wr_en,
   input  logic [QUANTUM_W-1:0] csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;

   // sequencing: idle (accept + table read), execute (dispatch only), commit
   rrts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   // job table, search, arithmetic and the output register
   rrts_dp #(.MAX_JOBS(MAX_JOBS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // a commit never overwrites a result that has not been transferred
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || !rsp_stall))
      else $error("commit while output register is occupied");

   // slice execution always directly follows a request transfer
   assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> $past(cmd.load))
      else $error("execute without a preceding accept");

   // a dispatched slice advances the clock by its own length
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_DISPATCHED) |->
         (rsp_data.clock_after == CLK_W'(rsp_data.slice_start + rsp_data.slice_length)))
      else $error("dispatch clock mismatch");

   // slice fields stay empty on everything but a dispatch
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_DISPATCHED) |->
         (rsp_data.slice_length == '0 && !rsp_data.job_finished &&
          rsp_data.slice_start == rsp_data.clock_after))
      else $error("slice fields set on a non-dispatch result");

endmodule

// ===== design/rrts_ram.sv =====
// -----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module rrts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rrts_ctrl.sv =====
// -----------------------------------------------------------------------------
// rrts_ctrl
// Sequencing state machine: accept, slice execution, result commit.
// -----------------------------------------------------------------------------
module rrts_ctrl import rrts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  opcode_type req_opcode,
   output logic       req_stall,
   input  stat_type   stat,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_opcode)
                  OP_DISPATCH: state_in = stat.found_valid ? S_EXEC : S_DONE;
                  OP_APPEND,
                  OP_CLEAR:    state_in = S_DONE;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_EXEC: state_in = S_DONE;
         S_DONE: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall  = 1'b1;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         S_EXEC: cmd.exec = 1'b1;
         S_DONE: cmd.commit = stat.out_free;
         default: req_stall = 1'b1;
      endcase
   end

endmodule

// ===== design/rrts_dp.sv =====
// -----------------------------------------------------------------------------
// rrts_dp
// Job table, pending search, slice arithmetic and result register.
// -----------------------------------------------------------------------------
module rrts_dp import rrts_pkg::*; #(
   parameter int MAX_JOBS = MAX_JOBS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  req_type              req_data,
   input  logic                 csr_wr_en,
   input  logic [QUANTUM_W-1:0] csr_wr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data
);

   localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W = $clog2(MAX_JOBS + 1);

   // architectural state
   logic [MAX_JOBS-1:0]  pending_ff, pending_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic [CLK_W-1:0]     clock_ff, clock_in;
   logic [WAIT_W-1:0]    wait_ff, wait_in;
   logic [QUANTUM_W-1:0] quantum_ff, quantum_in;

   // per-item registers
   opcode_type           op_ff;
   logic [BURST_W-1:0]   burst_ff;
   logic                 hit_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [CLK_W-1:0]     start_ff;
   logic [LEN_W-1:0]     len_ff;
   logic                 fin_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // pending search
   logic [MAX_JOBS-1:0]  ge_mask, masked, sel, onehot;
   logic [IDX_W-1:0]     found_idx;
   logic                 found_valid;

   // table access and slice arithmetic
   logic [BURST_W-1:0]   rem_rd, burst_rd, rem_wr_data;
   logic                 rem_wr_en, burst_wr_en;
   logic [IDX_W-1:0]     wr_addr, app_idx, scan_next;
   logic [QUANTUM_W-1:0] q_eff;
   logic [LEN_W-1:0]     len_c;
   logic                 fin_c, full, appending, dispatched;
   logic [CLK_W-1:0]     wait_add;

   // rotating priority encoder: lowest pending index at or above the pointer, else lowest
   always_comb begin
      found_idx = '0;
      for (int i = 0; i < MAX_JOBS; i++) begin
         ge_mask[i] = (i >= int'(scan_ff));
      end
      masked = pending_ff & ge_mask;
      sel    = (|masked) ? masked : pending_ff;
      onehot = sel & (~sel + MAX_JOBS'(1'b1));
      for (int i = 0; i < MAX_JOBS; i++) begin
         if (onehot[i]) begin
            found_idx = found_idx | IDX_W'(i);
         end
      end
   end

   assign found_valid      = |pending_ff;
   assign stat.found_valid = found_valid;
   assign stat.out_free    = !rsp_valid_ff || !rsp_stall;

   // slice arithmetic, zero quantum runs as one
   assign q_eff     = (quantum_ff == '0) ? QUANTUM_W'(1) : quantum_ff;
   assign fin_c     = (rem_rd <= q_eff);
   assign len_c     = fin_c ? rem_rd : q_eff;
   assign scan_next = (idx_ff == IDX_W'(MAX_JOBS - 1)) ? '0 : idx_ff + 1'b1;
   assign full      = (count_ff == CNT_W'(MAX_JOBS));
   assign app_idx   = count_ff[IDX_W-1:0];
   assign wait_add  = clock_ff - CLK_W'(burst_rd);

   assign appending  = cmd.commit && (op_ff == OP_APPEND) && !full;
   assign dispatched = (op_ff == OP_DISPATCH) && hit_ff;

   assign rem_wr_en   = cmd.exec || appending;
   assign burst_wr_en = appending;
   assign wr_addr     = cmd.exec ? idx_ff : app_idx;
   assign rem_wr_data = cmd.exec ? (rem_rd - len_c) : burst_ff;

   rrts_ram #(.WIDTH(BURST_W), .DEPTH(MAX_JOBS)) u_rem_ram (
      .clock   (clock),
      .wr_en   (rem_wr_en),
      .wr_addr (wr_addr),
      .wr_data (rem_wr_data),
      .rd_en   (cmd.load),
      .rd_addr (found_idx),
      .rd_data (rem_rd)
   );

   rrts_ram #(.WIDTH(BURST_W), .DEPTH(MAX_JOBS)) u_burst_ram (
      .clock   (clock),
      .wr_en   (burst_wr_en),
      .wr_addr (wr_addr),
      .wr_data (burst_ff),
      .rd_en   (cmd.load),
      .rd_addr (found_idx),
      .rd_data (burst_rd)
   );

   // state update
   always_comb begin
      pending_in = pending_ff;
      count_in   = count_ff;
      scan_in    = scan_ff;
      clock_in   = clock_ff;
      wait_in    = wait_ff;
      quantum_in = csr_wr_en ? csr_wr_data : quantum_ff;
      if (cmd.exec) begin
         clock_in = clock_ff + CLK_W'(len_c);
         scan_in  = scan_next;
         if (fin_c) begin
            pending_in[idx_ff] = 1'b0;
         end
      end
      if (cmd.commit) begin
         case (op_ff)
            OP_APPEND: begin
               if (!full) begin
                  pending_in[app_idx] = (burst_ff != '0);
                  count_in            = count_ff + 1'b1;
               end
            end
            OP_DISPATCH: begin
               if (hit_ff && fin_ff) begin
                  wait_in = wait_ff + WAIT_W'(wait_add);
               end
            end
            OP_CLEAR: begin
               pending_in = '0;
               count_in   = '0;
               scan_in    = '0;
               clock_in   = '0;
               wait_in    = '0;
            end
            default: pending_in = pending_ff;
         endcase
      end
   end

   // result assembly
   always_comb begin
      rsp_in              = rsp_ff;
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      if (cmd.commit) begin
         rsp_valid_in        = 1'b1;
         rsp_in.job_index    = '0;
         rsp_in.slice_start  = clock_in;
         rsp_in.slice_length = '0;
         rsp_in.job_finished = 1'b0;
         rsp_in.clock_after  = clock_in;
         rsp_in.wait_sum     = wait_in;
         rsp_in.job_count    = JOB_CNT_W'(count_in);
         case (op_ff)
            OP_APPEND: begin
               rsp_in.status = full ? STATUS_FULL : STATUS_APPENDED;
               if (!full) begin
                  rsp_in.job_index = JOB_IDX_W'(app_idx);
               end
            end
            OP_DISPATCH: begin
               rsp_in.status = hit_ff ? STATUS_DISPATCHED : STATUS_ALL_DONE;
               if (dispatched) begin
                  rsp_in.job_index    = JOB_IDX_W'(idx_ff);
                  rsp_in.slice_start  = start_ff;
                  rsp_in.slice_length = len_ff;
                  rsp_in.job_finished = fin_ff;
               end
            end
            default: rsp_in.status = STATUS_CLEARED;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         count_ff     <= '0;
         scan_ff      <= '0;
         clock_ff     <= '0;
         wait_ff      <= '0;
         quantum_ff   <= QUANTUM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         clock_ff     <= clock_in;
         wait_ff      <= wait_in;
         quantum_ff   <= quantum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_data.opcode;
         burst_ff <= req_data.burst;
         hit_ff   <= found_valid;
         idx_ff   <= found_idx;
         start_ff <= clock_ff;
      end
      if (cmd.exec) begin
         len_ff <= len_c;
         fin_ff <= fin_c;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
